// ===== rtl/core/rcsv_pkg.sv =====
// Package for the character sign-and-verify block.
// Holds default sizes, register indexes, reset values and state types.
// No dependencies.
package rcsv_pkg;

	// Default operand sizes.
	localparam int MOD_BITS_DEF = 16;
	localparam int EXP_BITS_DEF = 16;

	// Fixed field widths.
	localparam int CODE_W    = 7;
	localparam int REC_W     = 8;
	localparam int CFG_IDX_W = 2;

	// Offset between a character code and its signed base.
	localparam logic [REC_W-1:0] BASE_OFFSET = 8'd96;

	// Register reset values, cut to the register width at the point of use.
	localparam logic [31:0] MODULUS_RST  = 32'd3233;
	localparam logic [31:0] PRIV_EXP_RST = 32'd2753;
	localparam logic [31:0] PUB_EXP_RST  = 32'd17;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRIV_EXP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PUB_EXP  = 2'd2;

	// Exponentiation sequencer states.
	typedef enum logic [2:0] {
		EXP_IDLE,
		EXP_REDUCE_GO,
		EXP_REDUCE_WAIT,
		EXP_CHECK,
		EXP_MUL_GO,
		EXP_MUL_WAIT,
		EXP_SQR_GO,
		EXP_SQR_WAIT
	} exp_state_t;

	// Top-level phase of one item.
	typedef enum logic [1:0] {
		TOP_IDLE,
		TOP_SIGN,
		TOP_VERIFY
	} top_state_t;

endpackage

// ===== rtl/core/rsa_char_sign_verify.sv =====
// Top level of the character sign-and-verify block.
// Holds the key registers and the sign/verify phase control; uses rcsv_pkg,
// rcsv_modexp and rcsv_modmul.
//
// Usage:
//   Raise start with char_code while busy is low; the item is taken at that
//   edge and busy stays high until the result is given. The result is held on
//   signature, recovered_code and verified until the next result, marked by
//   done for exactly one cycle. The receiver cannot stall; it must take the
//   result in that cycle. Keys are written over the cfg_valid/cfg_ready
//   channel (cfg_index 0 is the modulus, 1 the private exponent, 2 the public
//   exponent); the user must write them only while idle, which the block
//   itself does not enforce. cfg_ready is always high and other indexes are
//   ignored.
//   Each modular multiply runs on the single shared bit-serial multiplier; an
//   exponentiation with a zero exponent uses none. done is registered after
//   the verify exponentiation, which follows the sign exponentiation. busy
//   falls in the done cycle, so the next item can be taken at the edge that
//   ends it.
//   Reset: arst_n clears control and loads the default keys; no item is
//   pending afterwards.
module rsa_char_sign_verify import rcsv_pkg::*; #(
	parameter int MOD_BITS = MOD_BITS_DEF,
	parameter int EXP_BITS = EXP_BITS_DEF,
	parameter int CFG_W    = (MOD_BITS > EXP_BITS) ? MOD_BITS : EXP_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [CODE_W-1:0]          char_code,
	output logic                       done,
	output logic signed [MOD_BITS:0]   signature,
	output logic [REC_W-1:0]           recovered_code,
	output logic                       verified,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_wdata
);

	top_state_t          state_q;
	top_state_t          state_nxt;

	logic [MOD_BITS-1:0] mod_q;
	logic [EXP_BITS-1:0] priv_q;
	logic [EXP_BITS-1:0] pub_q;
	logic [MOD_BITS:0]   n_eff;

	logic [CODE_W-1:0]   code_q;
	logic [MOD_BITS-1:0] sig_mag_q;
	logic                sig_neg_q;
	logic                done_q;
	logic [MOD_BITS:0]   signature_q;
	logic [REC_W-1:0]    rec_q;
	logic                verified_q;

	logic signed [REC_W-1:0] base_in;
	logic [CODE_W-1:0]   base_mag;
	logic                base_neg_q;

	logic                ex_start;
	logic [MOD_BITS-1:0] ex_mag;
	logic [EXP_BITS-1:0] ex_exp;
	logic                ex_done;
	logic [MOD_BITS-1:0] ex_res;

	logic                ver_neg;
	logic [MOD_BITS:0]   ver_val;
	logic [REC_W-1:0]    rec_val;

	rcsv_modexp #(
		.MOD_BITS (MOD_BITS),
		.EXP_BITS (EXP_BITS)
	) u_modexp (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ex_start),
		.base_mag (ex_mag),
		.exponent (ex_exp),
		.modulus  (n_eff),
		.done     (ex_done),
		.residue  (ex_res)
	);

	// Key registers; a zero modulus stands for two to the MOD_BITS.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q  <= MODULUS_RST[MOD_BITS-1:0];
			priv_q <= PRIV_EXP_RST[EXP_BITS-1:0];
			pub_q  <= PUB_EXP_RST[EXP_BITS-1:0];
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODULUS:  mod_q  <= cfg_wdata[MOD_BITS-1:0];
				REG_PRIV_EXP: priv_q <= cfg_wdata[EXP_BITS-1:0];
				REG_PUB_EXP:  pub_q  <= cfg_wdata[EXP_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign n_eff     = (mod_q == '0) ? {1'b1, {MOD_BITS{1'b0}}} : {1'b0, mod_q};

	// Signed base of the incoming character and its magnitude.
	always_comb begin
		base_in  = $signed({1'b0, char_code}) - $signed(BASE_OFFSET);
		base_mag = base_in[REC_W-1] ? CODE_W'(-base_in) : CODE_W'(base_in);
	end

	// Next phase.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			TOP_IDLE: begin
				if (start) begin
					state_nxt = TOP_SIGN;
				end
			end
			TOP_SIGN: begin
				if (ex_done) begin
					state_nxt = TOP_VERIFY;
				end
			end
			TOP_VERIFY: begin
				if (ex_done) begin
					state_nxt = TOP_IDLE;
				end
			end
			default: state_nxt = TOP_IDLE;
		endcase
	end

	// Exponentiation requests: sign with the input base, verify with the signature.
	always_comb begin
		ex_start = 1'b0;
		ex_mag   = MOD_BITS'(base_mag);
		ex_exp   = priv_q;
		unique case (state_q)
			TOP_IDLE: begin
				ex_start = start;
			end
			TOP_SIGN: begin
				ex_start = ex_done;
				ex_mag   = ex_res;
				ex_exp   = pub_q;
			end
			default: begin
				ex_start = 1'b0;
			end
		endcase
	end

	// Verify result: restore the sign, add the offset back, compare.
	always_comb begin
		ver_neg = sig_neg_q && pub_q[0] && (ex_res != '0);
		ver_val = ver_neg ? -{1'b0, ex_res} : {1'b0, ex_res};
		rec_val = ver_val[REC_W-1:0] + BASE_OFFSET;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TOP_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= (state_q == TOP_VERIFY) && ex_done;
		end
	end

	// Item data and result registers.
	always_ff @(posedge clk) begin
		if ((state_q == TOP_IDLE) && start) begin
			code_q     <= char_code;
			base_neg_q <= base_in[REC_W-1];
		end
		if ((state_q == TOP_SIGN) && ex_done) begin
			sig_mag_q <= ex_res;
			sig_neg_q <= base_neg_q && priv_q[0] && (ex_res != '0);
		end
		if ((state_q == TOP_VERIFY) && ex_done) begin
			signature_q <= sig_neg_q ? -{1'b0, sig_mag_q} : {1'b0, sig_mag_q};
			rec_q       <= rec_val;
			verified_q  <= (rec_val == {1'b0, code_q});
		end
	end

	assign busy           = (state_q != TOP_IDLE);
	assign done           = done_q;
	assign signature      = $signed(signature_q);
	assign recovered_code = rec_q;
	assign verified       = verified_q;

endmodule

// ===== rtl/core/rcsv_modmul.sv =====
// Bit-serial modular multiplier: product = (op_a * op_b) mod modulus.
// One bit of op_b per cycle, most significant first. Uses rcsv_pkg.
module rcsv_modmul import rcsv_pkg::*; #(
	parameter int MOD_BITS = MOD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [MOD_BITS-1:0] op_a,
	input  logic [MOD_BITS-1:0] op_b,
	input  logic [MOD_BITS:0]   modulus,
	output logic                done,
	output logic [MOD_BITS-1:0] product
);

	localparam int CNT_W = $clog2(MOD_BITS);
	localparam int T_W   = MOD_BITS + 2;

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [MOD_BITS-1:0] a_q;
	logic [MOD_BITS-1:0] b_q;
	logic [MOD_BITS-1:0] r_q;

	logic [T_W-1:0]      t_sum;
	logic [T_W-1:0]      n_one;
	logic [T_W-1:0]      n_two;
	logic [T_W-1:0]      t_red;

	// Double the partial residue, add the multiplicand when the bit is set,
	// then bring the sum below the modulus. The sum stays under three times it.
	always_comb begin
		n_one = {1'b0, modulus};
		n_two = {modulus, 1'b0};
		t_sum = {1'b0, r_q, 1'b0} + (b_q[MOD_BITS-1] ? {2'b00, a_q} : {T_W{1'b0}});
		if (t_sum >= n_two) begin
			t_red = t_sum - n_two;
		end else if (t_sum >= n_one) begin
			t_red = t_sum - n_one;
		end else begin
			t_red = t_sum;
		end
	end

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(MOD_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Operand and residue registers.
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			a_q <= op_a;
			b_q <= op_b;
			r_q <= '0;
		end else if (busy_q) begin
			b_q <= {b_q[MOD_BITS-2:0], 1'b0};
			r_q <= t_red[MOD_BITS-1:0];
		end
	end

	assign done    = done_q;
	assign product = r_q;

endmodule

// ===== rtl/core/rcsv_modexp.sv =====
// Square-and-multiply sequencer: residue = base_mag^exponent mod modulus.
// Drives one shared rcsv_modmul. Uses rcsv_pkg.
module rcsv_modexp import rcsv_pkg::*; #(
	parameter int MOD_BITS = MOD_BITS_DEF,
	parameter int EXP_BITS = EXP_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [MOD_BITS-1:0] base_mag,
	input  logic [EXP_BITS-1:0] exponent,
	input  logic [MOD_BITS:0]   modulus,
	output logic                done,
	output logic [MOD_BITS-1:0] residue
);

	exp_state_t          state_q;
	exp_state_t          state_nxt;
	logic                done_q;
	logic [EXP_BITS-1:0] e_q;
	logic [MOD_BITS-1:0] mag_q;
	logic [MOD_BITS-1:0] acc_q;
	logic [MOD_BITS-1:0] sq_q;

	logic                mm_start;
	logic [MOD_BITS-1:0] mm_a;
	logic [MOD_BITS-1:0] mm_b;
	logic                mm_done;
	logic [MOD_BITS-1:0] mm_prod;

	rcsv_modmul #(
		.MOD_BITS (MOD_BITS)
	) u_modmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mm_start),
		.op_a    (mm_a),
		.op_b    (mm_b),
		.modulus (modulus),
		.done    (mm_done),
		.product (mm_prod)
	);

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			EXP_IDLE: begin
				if (start) begin
					state_nxt = (exponent == '0) ? EXP_IDLE : EXP_REDUCE_GO;
				end
			end
			EXP_REDUCE_GO: state_nxt = EXP_REDUCE_WAIT;
			EXP_REDUCE_WAIT: begin
				if (mm_done) begin
					state_nxt = EXP_CHECK;
				end
			end
			EXP_CHECK: begin
				if (e_q == '0) begin
					state_nxt = EXP_IDLE;
				end else if (e_q[0]) begin
					state_nxt = EXP_MUL_GO;
				end else begin
					state_nxt = EXP_SQR_GO;
				end
			end
			EXP_MUL_GO: state_nxt = EXP_MUL_WAIT;
			EXP_MUL_WAIT: begin
				if (mm_done) begin
					state_nxt = EXP_SQR_GO;
				end
			end
			EXP_SQR_GO: state_nxt = EXP_SQR_WAIT;
			EXP_SQR_WAIT: begin
				if (mm_done) begin
					state_nxt = EXP_CHECK;
				end
			end
			default: state_nxt = EXP_IDLE;
		endcase
	end

	// Multiplier requests: reduce the base first, then multiply or square.
	always_comb begin
		mm_start = 1'b0;
		mm_a     = sq_q;
		mm_b     = sq_q;
		unique case (state_q)
			EXP_REDUCE_GO: begin
				mm_start = 1'b1;
				mm_a     = MOD_BITS'(1);
				mm_b     = mag_q;
			end
			EXP_MUL_GO: begin
				mm_start = 1'b1;
				mm_a     = acc_q;
			end
			EXP_SQR_GO: begin
				mm_start = 1'b1;
			end
			default: begin
				mm_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EXP_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= ((state_q == EXP_IDLE) && start && (exponent == '0)) ||
			           ((state_q == EXP_CHECK) && (e_q == '0));
		end
	end

	// Working registers. A zero exponent gives 1 without any reduction.
	always_ff @(posedge clk) begin
		if ((state_q == EXP_IDLE) && start) begin
			e_q   <= exponent;
			mag_q <= base_mag;
			if ((exponent == '0) || (modulus != (MOD_BITS + 1)'(1))) begin
				acc_q <= MOD_BITS'(1);
			end else begin
				acc_q <= '0;
			end
		end else if (mm_done) begin
			if (state_q == EXP_REDUCE_WAIT) begin
				sq_q <= mm_prod;
			end else if (state_q == EXP_MUL_WAIT) begin
				acc_q <= mm_prod;
			end else if (state_q == EXP_SQR_WAIT) begin
				sq_q <= mm_prod;
				e_q  <= e_q >> 1;
			end
		end
	end

	assign done    = done_q;
	assign residue = acc_q;

endmodule

// ===== tb/rcsv_checker.sv =====
`timescale 1ns / 100ps
// Checker for the character sign-and-verify block: tracks the key registers,
// predicts the result of every accepted item and compares it field by field.
// Depends on rcsv_pkg.
module rcsv_checker import rcsv_pkg::*; #(
	parameter int MOD_BITS = MOD_BITS_DEF,
	parameter int EXP_BITS = EXP_BITS_DEF,
	parameter int CFG_W    = (MOD_BITS > EXP_BITS) ? MOD_BITS : EXP_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic [CODE_W-1:0]        char_code,
	input  logic                     done,
	input  logic signed [MOD_BITS:0] signature,
	input  logic [REC_W-1:0]         recovered_code,
	input  logic                     verified,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_wdata,
	output int                       fail_count,
	output int                       pending
);

	typedef struct {
		logic [CODE_W-1:0]        code;
		logic signed [MOD_BITS:0] sig;
		logic [REC_W-1:0]         rec;
		logic                     ok;
	} char_result_t;

	// Results still owed by the block, oldest first.
	char_result_t expected_results[$];

	// Local copy of the key registers.
	logic [MOD_BITS-1:0] key_modulus;
	logic [EXP_BITS-1:0] key_private;
	logic [EXP_BITS-1:0] key_public;

	// Square-and-multiply on the magnitude; the sign follows the base when the
	// exponent is odd, and a zero residue stays unsigned.
	function automatic longint trunc_modpow(longint base, longint unsigned ex,
			longint unsigned n);
		longint unsigned mag;
		longint unsigned acc;
		longint unsigned sq;
		longint unsigned e;
		logic neg;
		if (ex == 0) begin
			return 1;
		end
		neg = (base < 0) && ex[0];
		mag = (base < 0) ? -base : base;
		sq = mag % n;
		acc = 1 % n;
		e = ex;
		while (e != 0) begin
			if (e[0]) begin
				acc = (acc * sq) % n;
			end
			sq = (sq * sq) % n;
			e = e >> 1;
		end
		if (neg && acc != 0) begin
			return -longint'(acc);
		end
		return longint'(acc);
	endfunction

	// Sign the character, verify the signature and rebuild the code.
	function automatic char_result_t predict_sign_verify(logic [CODE_W-1:0] code);
		char_result_t r;
		longint unsigned n;
		longint sig;
		longint ver;
		n = (key_modulus == 0) ? (64'd1 << MOD_BITS) : 64'(key_modulus);
		sig = trunc_modpow(longint'(code) - longint'(BASE_OFFSET), key_private, n);
		ver = trunc_modpow(sig, key_public, n);
		r.code = code;
		r.sig = sig[MOD_BITS:0];
		r.rec = ver[REC_W-1:0] + BASE_OFFSET;
		r.ok = (r.rec == REC_W'(code));
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("ERROR %0t: %s", $time, msg);
		fail_count++;
	endtask

	// Results are compared before new items are queued, so a result and an
	// item on the same edge pair up correctly.
	always @(posedge clk or negedge arst_n) begin : watch
		char_result_t want;
		if (!arst_n) begin
			key_modulus = MOD_BITS'(MODULUS_RST);
			key_private = EXP_BITS'(PRIV_EXP_RST);
			key_public  = EXP_BITS'(PUB_EXP_RST);
			expected_results.delete();
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with no item pending");
				end else begin
					want = expected_results.pop_front();
					if (signature !== want.sig) begin
						report_mismatch($sformatf("code %0d: signature %0d, expected %0d",
							want.code, signature, want.sig));
					end
					if (recovered_code !== want.rec) begin
						report_mismatch($sformatf("code %0d: recovered_code %0d, expected %0d",
							want.code, recovered_code, want.rec));
					end
					if (verified !== want.ok) begin
						report_mismatch($sformatf("code %0d: verified %0b, expected %0b",
							want.code, verified, want.ok));
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODULUS: begin
						key_modulus = cfg_wdata[MOD_BITS-1:0];
					end
					REG_PRIV_EXP: begin
						key_private = cfg_wdata[EXP_BITS-1:0];
					end
					REG_PUB_EXP: begin
						key_public = cfg_wdata[EXP_BITS-1:0];
					end
					default: begin
					end
				endcase
			end
			if (start && !busy) begin
				expected_results.push_back(predict_sign_verify(char_code));
			end
		end
		pending = expected_results.size();
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Top of the testbench for the character sign-and-verify block: clock, reset,
// item and key-write stimulus, watchdog and verdict.
// Depends on rcsv_pkg, rsa_char_sign_verify and rcsv_checker.
module testbench;
	import rcsv_pkg::*;

	localparam int MOD_BITS   = MOD_BITS_DEF;
	localparam int EXP_BITS   = EXP_BITS_DEF;
	localparam int CFG_W      = (MOD_BITS > EXP_BITS) ? MOD_BITS : EXP_BITS;
	localparam int IDLE_LIMIT = 20000;
	localparam int PHASES     = 10;
	localparam int PHASE_LEN  = 48;

	// Index with no register behind it; writes to it must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [CODE_W-1:0]        char_code;
	logic                     done;
	logic signed [MOD_BITS:0] signature;
	logic [REC_W-1:0]         recovered_code;
	logic                     verified;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_W-1:0]         cfg_wdata;
	int                       fail_count;
	int                       pending;
	int                       idle_cycles;
	logic                     no_idle;

	// Codes at the ends of the range and around the base offset.
	logic [CODE_W-1:0] corner_codes [10] = '{7'd0, 7'd127, 7'd96, 7'd97, 7'd95,
		7'd1, 7'd31, 7'd32, 7'd122, 7'd64};

	// Matching key triples: modulus, private exponent, public exponent.
	logic [15:0] rsa_keys [5][3] = '{'{16'd3233, 16'd2753, 16'd17},
		'{16'd55, 16'd27, 16'd3}, '{16'd33, 16'd7, 16'd3},
		'{16'd143, 16'd103, 16'd7}, '{16'd65, 16'd29, 16'd5}};

	logic [15:0] key_extremes [4] = '{16'd0, 16'd1, 16'd2, 16'hFFFF};

	rsa_char_sign_verify #(.MOD_BITS(MOD_BITS), .EXP_BITS(EXP_BITS)) u_top (.*);

	rcsv_checker #(.MOD_BITS(MOD_BITS), .EXP_BITS(EXP_BITS)) u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one; none in a no-idle stretch.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 40) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 15);
		end
		return $urandom_range(30, 700);
	endfunction

	// Lowercase letters make up most messages; the rest spans every code.
	function automatic logic [CODE_W-1:0] pick_code();
		if ($urandom_range(0, 9) < 7) begin
			return CODE_W'($urandom_range(97, 122));
		end
		return CODE_W'($urandom_range(0, 127));
	endfunction

	// Present one item and hold it until the block takes it.
	task automatic send_char(input logic [CODE_W-1:0] code);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		char_code <= code;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Stop issuing items and wait for every owed result.
	task automatic drain();
		start <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Load all three keys once the block is idle, plus one ignored write.
	task automatic set_keys(input logic [15:0] modulus, input logic [15:0] priv,
			input logic [15:0] pub);
		drain();
		write_key(REG_MODULUS, modulus);
		write_key(REG_PRIV_EXP, priv);
		write_key(REG_PUB_EXP, pub);
		write_key(REG_UNUSED, CFG_W'($urandom()));
		cfg_valid <= 1'b0;
	endtask

	// Stimulus: directed corners first, then random key phases.
	initial begin : stimulus
		int pick;
		int row;
		start = 1'b0;
		char_code = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		no_idle = 1'b0;
		arst_n = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset keys.
		foreach (corner_codes[i]) begin
			send_char(corner_codes[i]);
		end

		// Zero modulus stands for the full range; largest exponents.
		set_keys(16'd0, 16'hFFFF, 16'hFFFF);
		send_char(7'd0);
		send_char(7'd127);
		send_char(7'd97);
		send_char(7'd96);

		// Modulus one: zero exponent still gives one, any other gives zero.
		set_keys(16'd1, 16'd0, 16'd5);
		send_char(7'd0);
		send_char(7'd96);
		send_char(7'd127);

		// Modulus two with a zero public exponent.
		set_keys(16'd2, 16'd1, 16'd0);
		send_char(7'd0);
		send_char(7'd95);
		send_char(7'd127);

		set_keys(16'hFFFF, 16'hFFFF, 16'd1);
		send_char(7'd0);
		send_char(7'd127);

		// Random phases: valid key pairs, random keys and extreme keys.
		for (int ph = 0; ph < PHASES; ph++) begin
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				row = $urandom_range(0, 4);
				set_keys(rsa_keys[row][0], rsa_keys[row][1], rsa_keys[row][2]);
			end else if (pick < 7) begin
				set_keys(16'($urandom()), 16'($urandom()), 16'($urandom()));
			end else begin
				set_keys(key_extremes[$urandom_range(0, 3)], key_extremes[$urandom_range(0, 3)],
					key_extremes[$urandom_range(0, 3)]);
			end
			no_idle = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < PHASE_LEN; i++) begin
				send_char(pick_code());
			end
		end

		drain();
		repeat (50) @(negedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog: ends the run when no item, key write or result has come for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

// ===== sim.f =====
rtl/core/rcsv_pkg.sv
rtl/core/rcsv_modmul.sv
rtl/core/rcsv_modexp.sv
rtl/core/rsa_char_sign_verify.sv
tb/rcsv_checker.sv
tb/testbench.sv
